/* design/skli_pkg.sv */
// skli_pkg: types and constants shared by the sorted key list cells and top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package skli_pkg;

	localparam int KeyWidth   = 32;
	localparam int MaxResults = 32;
	localparam int PosWidth   = 5;
	localparam int CountWidth = 6;

	typedef logic signed [KeyWidth-1:0] key_t;

	// what every cell does in a cycle
	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

endpackage

`default_nettype wire

/* design/skli_cell.sv */
// skli_cell: one place of the sorted key chain, holds a single key
// depends on skli_pkg
`timescale 1ns / 1ps
`default_nettype none

module skli_cell (
	input  wire                     clk,
	input  skli_pkg::cell_ctrl_t    ctrl,
	input  skli_pkg::key_t          new_key,
	input  skli_pkg::key_t          left_key,
	input  skli_pkg::key_t          right_key,
	input  skli_pkg::key_t          head_key,
	input  wire                     valid,
	input  wire                     last_valid,
	input  wire                     left_keep,
	output skli_pkg::key_t          key_q,
	output logic                    keep
);
	import skli_pkg::*;

	// a held key smaller than the new one stays in place
	assign keep = valid && (key_q < new_key);

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!keep) begin
				key_q <= left_keep ? new_key : left_key;
			end
		end else if (ctrl.rotate) begin
			// ring over the occupied places only
			key_q <= last_valid ? head_key : right_key;
		end
	end

endmodule

`default_nettype wire

/* design/sorted_key_list_insert_top.sv */
// sorted_key_list_insert_top: sorted store of signed keys built as a chain of cells
// depends on skli_pkg and skli_cell
//
// Input channel (in_valid/in_ready) takes items of mode and key. mode 0 inserts key
// after every held key that is smaller; one result gives the position taken and the
// new count. With the store full the insert is dropped and flagged by full_error.
// mode 1 reads out the held keys, at most MaxResults, in ascending order, one result
// per cycle unless the receiver stalls, the final one marked by last; an empty store
// gives one result with item_valid low. Output channel (out_valid/out_ready) is a
// single output register. An insert or empty read out result is registered, valid
// in the cycle after its item is accepted; a read out's first key passes through
// ST_DUMP, then the output register. One insert per cycle when the output is not
// stalled; all cells compare and shift at once. A read out rotates the chain one
// place per cycle past the head cell, holding on a stall; no item is taken until
// the rotation is back in order. When the receiver stalls the output register
// holds and in_ready drops, so nothing is lost. Reset clears the key count; the
// cell contents are undefined until written and are never read beyond the count.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_list_insert_top #(
	parameter int CAPACITY = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [0:0]         mode,
	input  skli_pkg::key_t     key,
	output logic               out_valid,
	input  wire                out_ready,
	output skli_pkg::key_t     key_out,
	output logic [4:0]         position,
	output logic [5:0]         stored_count_out,
	output logic               full_error,
	output logic               item_valid,
	output logic               last
);
	import skli_pkg::*;

	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic            out_valid_q;
	key_t            key_out_q;
	logic [4:0]      position_q;
	logic [5:0]      count_out_q;
	logic            full_error_q, item_valid_q, last_q;

	key_t            cell_key [CAPACITY];
	logic [CAPACITY-1:0] cell_keep, cell_valid, cell_last_valid, boundary;
	cell_ctrl_t      ctrl;

	logic            slot_free, in_fire, is_full, do_insert, step, emit_now, out_load;
	logic [PW-1:0]   pos_idx;
	logic [6:0]      pos_wide, count_wide, idx_wide, emit_wide;

	assign slot_free = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign is_full   = (count_q == CW'(CAPACITY));
	assign do_insert = in_fire && !mode[0] && !is_full;

	// occupied places and the last of them, from the count
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_valid[i] = count_q > CW'(i);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == CAPACITY - 1) begin
				cell_last_valid[i] = cell_valid[i];
			end else begin
				cell_last_valid[i] = cell_valid[i] && !cell_valid[i+1];
			end
		end
	end

	// the new key lands at the first place that does not keep its key
	always_comb begin
		pos_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (i == 0) begin
				boundary[i] = !cell_keep[i];
			end else begin
				boundary[i] = !cell_keep[i] && cell_keep[i-1];
			end
			if (boundary[i]) begin
				pos_idx = pos_idx | PW'(i);
			end
		end
	end

	assign ctrl.insert = do_insert;
	assign ctrl.rotate = step;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		skli_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_key    (key),
			.left_key   ((g == 0) ? key : cell_key[(g == 0) ? 0 : g-1]),
			.right_key  ((g == CAPACITY-1) ? cell_key[0]
			                               : cell_key[(g == CAPACITY-1) ? g : g+1]),
			.head_key   (cell_key[0]),
			.valid      (cell_valid[g]),
			.last_valid (cell_last_valid[g]),
			.left_keep  ((g == 0) ? 1'b1 : cell_keep[(g == 0) ? 0 : g-1]),
			.key_q      (cell_key[g]),
			.keep       (cell_keep[g])
		);
	end

	assign count_wide = 7'(count_q);
	assign idx_wide   = 7'(idx_q);
	assign pos_wide   = 7'(pos_idx);
	assign emit_wide  = (count_wide > 7'(MaxResults)) ? 7'(MaxResults) : count_wide;
	assign emit_now   = idx_wide < emit_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		step     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = slot_free;
				if (in_valid && slot_free && mode[0] && count_q != '0) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				// keys past the result limit still rotate, without a result
				step = emit_now ? slot_free : 1'b1;
				if (step && idx_q == count_q - CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + CW'(1);
			end
			if (in_fire) begin
				idx_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// a read out of a non-empty store gives its results from the rotation only
	assign out_load = (in_fire && !(mode[0] && count_q != '0)) || (step && emit_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (step) begin
				key_out_q    <= cell_key[0];
				position_q   <= idx_wide[4:0];
				count_out_q  <= count_wide[5:0];
				full_error_q <= 1'b0;
				item_valid_q <= 1'b1;
				last_q       <= (idx_wide + 7'd1 == emit_wide);
			end else if (mode[0]) begin
				// read out of an empty store
				key_out_q    <= '0;
				position_q   <= '0;
				count_out_q  <= '0;
				full_error_q <= 1'b0;
				item_valid_q <= 1'b0;
				last_q       <= 1'b1;
			end else if (is_full) begin
				key_out_q    <= key;
				position_q   <= '0;
				count_out_q  <= count_wide[5:0];
				full_error_q <= 1'b1;
				item_valid_q <= 1'b1;
				last_q       <= 1'b1;
			end else begin
				key_out_q    <= key;
				position_q   <= pos_wide[4:0];
				count_out_q  <= 6'(count_wide + 7'd1);
				full_error_q <= 1'b0;
				item_valid_q <= 1'b1;
				last_q       <= 1'b1;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign key_out          = key_out_q;
	assign position         = position_q;
	assign stored_count_out = count_out_q;
	assign full_error       = full_error_q;
	assign item_valid       = item_valid_q;
	assign last             = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("key count beyond capacity");

	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |-> $onehot(boundary))
		else $error("insert does not find exactly one free place");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> count_q != '0 && idx_q < count_q)
		else $error("read out runs past the held keys");

	a_no_take_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> !in_ready)
		else $error("item taken during read out");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> count_q == $past(count_q) + CW'(1))
		else $error("count not advanced after insert");
`endif

endmodule

`default_nettype wire

/* sim/sorted_key_list_insert_top_test.sv */
// sorted_key_list_insert_top_test: self-checking bench for the sorted key store
// depends on skli_pkg and sorted_key_list_insert_top; predicts every result in-bench
`timescale 1ns / 1ps

module sorted_key_list_insert_top_test;

	localparam int Capacity = 32;
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DUMP   = 1'b1;
	localparam key_min = 32'sh8000_0000;
	localparam key_max = 32'sh7fff_ffff;

	typedef struct {
		skli_pkg::key_t key_out;
		logic [4:0]     position;
		logic [5:0]     stored_count;
		logic           full_error;
		logic           item_valid;
		logic           last;
	} sorter_result_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	logic [0:0]     mode;
	skli_pkg::key_t key;
	logic           out_valid;
	logic           out_ready;
	skli_pkg::key_t key_out;
	logic [4:0]     position;
	logic [5:0]     stored_count_out;
	logic           full_error;
	logic           item_valid;
	logic           last;

	// in-bench copy of the store
	skli_pkg::key_t held_keys [Capacity];
	int             held_count;
	sorter_result_t pending_results [$];
	int             mismatches;
	bit             idle_on;
	int             out_stall_left;

	sorted_key_list_insert_top #(.CAPACITY(Capacity)) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.key              (key),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.key_out          (key_out),
		.position         (position),
		.stored_count_out (stored_count_out),
		.full_error       (full_error),
		.item_valid       (item_valid),
		.last             (last)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	// works out the results of one accepted item and updates the held keys
	task automatic predict_sorted_insert(input logic m, input skli_pkg::key_t k);
		sorter_result_t r;
		int slot;
		int emit;
		r.full_error = 1'b0;
		r.item_valid = 1'b1;
		r.last       = 1'b1;
		if (m == MODE_INSERT) begin
			r.key_out = k;
			if (held_count >= Capacity) begin
				r.position     = '0;
				r.stored_count = 6'(held_count);
				r.full_error   = 1'b1;
			end else begin
				// new key goes ahead of any equal keys
				slot = 0;
				while (slot < held_count && held_keys[slot] < k)
					slot++;
				for (int i = held_count; i > slot; i--)
					held_keys[i] = held_keys[i-1];
				held_keys[slot] = k;
				held_count++;
				r.position     = 5'(slot);
				r.stored_count = 6'(held_count);
			end
			pending_results.push_back(r);
		end else if (held_count == 0) begin
			r.key_out      = '0;
			r.position     = '0;
			r.stored_count = '0;
			r.item_valid   = 1'b0;
			pending_results.push_back(r);
		end else begin
			emit = (held_count > skli_pkg::MaxResults) ? skli_pkg::MaxResults : held_count;
			for (int i = 0; i < emit; i++) begin
				r.key_out      = held_keys[i];
				r.position     = 5'(i);
				r.stored_count = 6'(held_count);
				r.last         = (i == emit - 1);
				pending_results.push_back(r);
			end
		end
	endtask

	// drives one item, holds it until taken, then predicts its results
	task automatic send_item(input logic m, input skli_pkg::key_t k);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		key      <= k;
		do
			@(posedge clk);
		while (!in_ready);
		predict_sorted_insert(m, k);
	endtask

	// drops the input and waits until every expected result has come
	task automatic wait_for_results;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	function automatic skli_pkg::key_t pick_key;
		case ($urandom_range(0, 7))
			0:       return key_min;
			1:       return key_max;
			2, 3:    return skli_pkg::key_t'($signed($urandom_range(0, 8)) - 4);
			default: return skli_pkg::key_t'($urandom);
		endcase
	endfunction

	task automatic test_empty_dump;
		send_item(MODE_DUMP, 32'sh5a5a_a5a5);
	endtask

	task automatic test_extreme_keys;
		send_item(MODE_INSERT, 32'sd0);
		send_item(MODE_INSERT, key_max);
		send_item(MODE_INSERT, key_min);
		send_item(MODE_INSERT, -32'sd1);
		send_item(MODE_INSERT, 32'sd1);
		send_item(MODE_INSERT, key_max);
		send_item(MODE_INSERT, key_min);
		send_item(MODE_DUMP, key_max);
	endtask

	task automatic test_equal_keys;
		send_item(MODE_INSERT, 32'sd7);
		send_item(MODE_INSERT, 32'sd7);
		send_item(MODE_INSERT, 32'sd7);
		send_item(MODE_INSERT, 32'sd0);
		send_item(MODE_INSERT, -32'sd1);
		send_item(MODE_DUMP, 32'sd0);
	endtask

	task automatic test_random_items(input int count);
		for (int n = 0; n < count; n++) begin
			// one full drain part way through
			if (n == count / 3)
				wait_for_results();
			if ($urandom_range(0, 6) == 0)
				send_item(MODE_DUMP, skli_pkg::key_t'($urandom));
			else
				send_item(MODE_INSERT, pick_key());
		end
	endtask

	task automatic test_store_full;
		while (held_count < Capacity)
			send_item(MODE_INSERT, pick_key());
		send_item(MODE_DUMP, -32'sd1);
		send_item(MODE_INSERT, key_max);
		send_item(MODE_INSERT, key_min);
		send_item(MODE_INSERT, 32'sd0);
		send_item(MODE_DUMP, 32'sd0);
		send_item(MODE_DUMP, key_min);
	endtask

	task automatic report_field(input string name, input longint want, input longint got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
	endtask

	// receiver with random stall bursts
	always @(posedge clk) begin
		if (out_stall_left != 0) begin
			out_stall_left <= out_stall_left - 1;
			out_ready      <= (out_stall_left == 1);
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			out_stall_left <= $urandom_range(1, 19);
			out_ready      <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		sorter_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, expected none, actual key %0h",
				         $time, key_out);
			end else begin
				want = pending_results.pop_front();
				if (key_out !== want.key_out)
					report_field("key_out", want.key_out, key_out);
				if (position !== want.position)
					report_field("position", want.position, position);
				if (stored_count_out !== want.stored_count)
					report_field("stored_count_out", want.stored_count, stored_count_out);
				if (full_error !== want.full_error)
					report_field("full_error", want.full_error, full_error);
				if (item_valid !== want.item_valid)
					report_field("item_valid", want.item_valid, item_valid);
				if (last !== want.last)
					report_field("last", want.last, last);
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       <= 1'b0;
		mode           <= MODE_INSERT;
		key            <= '0;
		out_ready      <= 1'b0;
		out_stall_left = 0;
		held_count     = 0;
		mismatches     = 0;
		idle_on        = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_dump();
		test_extreme_keys();
		test_equal_keys();
		test_random_items(200);
		// closing stretch runs flat out
		idle_on = 1'b0;
		test_random_items(30);
		test_store_full();

		wait_for_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
